// ----- rtl/core/prqs_pkg.sv -----
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types and constants for the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package prqs_pkg;

    localparam int TASK_ID_W = 4;
    localparam int PRIO_W    = 2;

    // request codes
    typedef enum logic [0:0] {
        OP_MAKE_READY = 1'b0,
        OP_SCHEDULE   = 1'b1
    } op_t;

    typedef struct packed {
        op_t                  operation;
        logic [TASK_ID_W-1:0] task_id;
        logic [PRIO_W-1:0]    task_priority;
        logic                 current_running;
    } in_item_t;

    typedef struct packed {
        logic [TASK_ID_W-1:0] running_task;
        logic                 running_present;
        logic                 switched;
        logic                 no_task_error;
        logic                 queue_full;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/priority_ready_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Strict-priority ready-queue scheduler, round robin inside each level.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry requests: make_ready appends task_id to the
//   tail of level task_priority (level 0 highest), schedule pops the head of
//   the highest non-empty level and, if the current task is still running,
//   puts it back at the tail of its own level.
//   m_valid/m_ready/m_item return one result transaction per request.
//   Timing: a request is registered on acceptance and processed in a cycle
//   in which the output register is free or being emptied; its result is
//   loaded into the output register at the end of that cycle, which drives m_valid.
//   Throughput: one request per cycle while m_ready is high, any mix of
//   operations. The queue storage is one memory with one write and one
//   registered read port; each level keeps its head entry in a register,
//   refilled by the read port after a pop in time for a pop the very next cycle.
//   Reset (aresetn low, synchronous): all levels empty, no task running,
//   both pipeline stages empty. No clearing pass is needed.
//   Receiver stall: the output register holds its result; the input register
//   takes one more request, then s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue_scheduler #(
    parameter int PRIORITY_LEVELS = 4,
    parameter int MAX_TASKS       = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire prqs_pkg::in_item_t s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output prqs_pkg::out_item_t     m_item
);

    localparam int LVL_W  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int SUM_W  = $clog2(2 * MAX_TASKS);
    localparam int DEPTH  = PRIORITY_LEVELS * MAX_TASKS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ID_W   = prqs_pkg::TASK_ID_W;

    // ------------------------------------------------------------------
    // input register and output register
    // ------------------------------------------------------------------
    prqs_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg;
    prqs_pkg::out_item_t out_item_reg, out_item_next;
    logic                out_valid_reg;
    logic                fire;

    // processing happens when the output slot is free or being emptied
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (fire) begin
            out_item_reg <= out_item_next;
        end
    end

    // ------------------------------------------------------------------
    // queue state
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] head_reg [PRIORITY_LEVELS];
    logic [SLOT_W-1:0] head_next [PRIORITY_LEVELS];
    logic [CNT_W-1:0]  cnt_reg  [PRIORITY_LEVELS];
    logic [CNT_W-1:0]  cnt_next [PRIORITY_LEVELS];
    logic [CNT_W-1:0]  cnt_mid  [PRIORITY_LEVELS];
    // cached head entry of each level
    logic [ID_W-1:0]   hv_reg   [PRIORITY_LEVELS];
    logic [ID_W-1:0]   hv_next  [PRIORITY_LEVELS];
    logic [ID_W-1:0]   hv_eff   [PRIORITY_LEVELS];

    logic [ID_W-1:0]   cur_task_reg,  cur_task_next;
    logic [LVL_W-1:0]  cur_level_reg, cur_level_next;
    logic              cur_valid_reg, cur_valid_next;

    // refill of a head cache from the memory, in the cycle after a pop
    logic              pend_valid_reg, pend_valid_next;
    logic [LVL_W-1:0]  pend_lvl_reg,   pend_lvl_next;

    // memory
    logic [ID_W-1:0]   queue_mem_reg [DEPTH];
    logic [ID_W-1:0]   rd_data_reg;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [ID_W-1:0]   wr_data;

    // decision signals
    logic              found;
    logic [LVL_W-1:0]  pick_lvl;
    logic              still;
    logic              is_sched;
    logic              pop_en;
    logic              push_en;
    logic              push_ok;
    logic              push_full;
    logic [LVL_W-1:0]  push_lvl;
    logic [LVL_W-1:0]  req_lvl;
    logic [ID_W-1:0]   push_id;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  head_sum;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] new_head;

    // head entry as seen this cycle
    always_comb begin
        for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            hv_eff[l] = (pend_valid_reg && pend_lvl_reg == LVL_W'(l)) ? rd_data_reg
                                                                        : hv_reg[l];
        end
    end

    // highest non-empty level
    always_comb begin
        found    = 1'b0;
        pick_lvl = '0;
        for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
            if (cnt_reg[l] != '0) begin
                found    = 1'b1;
                pick_lvl = LVL_W'(l);
            end
        end
    end

    // requested level, saturated to the lowest level
    assign req_lvl = (32'(in_item_reg.task_priority) >= PRIORITY_LEVELS)
                   ? LVL_W'(PRIORITY_LEVELS - 1) : LVL_W'(in_item_reg.task_priority);

    assign is_sched = (in_item_reg.operation == prqs_pkg::OP_SCHEDULE);
    assign still    = in_item_reg.current_running && cur_valid_reg;
    assign pop_en   = fire && is_sched && found;
    assign push_en  = fire && (!is_sched || (found && still));
    assign push_lvl = is_sched ? cur_level_reg : req_lvl;
    assign push_id  = is_sched ? cur_task_reg  : in_item_reg.task_id;

    // pop first, then append, as one step
    always_comb begin
        for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            cnt_mid[l]  = cnt_reg[l];
            head_next[l] = head_reg[l];
        end
        head_sum = SUM_W'(head_reg[pick_lvl]) + SUM_W'(1);
        new_head = (head_sum >= SUM_W'(MAX_TASKS)) ? SLOT_W'(head_sum - SUM_W'(MAX_TASKS))
                                                   : SLOT_W'(head_sum);
        if (pop_en) begin
            cnt_mid[pick_lvl]   = cnt_reg[pick_lvl] - CNT_W'(1);
            head_next[pick_lvl] = new_head;
        end

        push_full = (cnt_mid[push_lvl] == CNT_W'(MAX_TASKS));
        push_ok   = push_en && !push_full;
        tail_sum  = SUM_W'(head_next[push_lvl]) + SUM_W'(cnt_mid[push_lvl]);
        tail_slot = (tail_sum >= SUM_W'(MAX_TASKS)) ? SLOT_W'(tail_sum - SUM_W'(MAX_TASKS))
                                                    : SLOT_W'(tail_sum);

        for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            cnt_next[l] = cnt_mid[l];
            hv_next[l]  = hv_eff[l];
        end
        if (push_ok) begin
            cnt_next[push_lvl] = cnt_mid[push_lvl] + CNT_W'(1);
            // append to an empty level: the new entry is the head
            if (cnt_mid[push_lvl] == '0) begin
                hv_next[push_lvl] = push_id;
            end
        end

        // refill the head cache of the popped level if entries remain
        rd_en           = pop_en && (cnt_mid[pick_lvl] != '0);
        rd_addr         = ADDR_W'(ADDR_W'(pick_lvl) * ADDR_W'(MAX_TASKS) + ADDR_W'(new_head));
        pend_valid_next = rd_en;
        pend_lvl_next   = pick_lvl;

        wr_en   = push_ok;
        wr_addr = ADDR_W'(ADDR_W'(push_lvl) * ADDR_W'(MAX_TASKS) + ADDR_W'(tail_slot));
        wr_data = push_id;
    end

    // running task
    always_comb begin
        cur_task_next  = cur_task_reg;
        cur_level_next = cur_level_reg;
        cur_valid_next = cur_valid_reg;
        if (pop_en) begin
            cur_task_next  = hv_eff[pick_lvl];
            cur_level_next = pick_lvl;
            cur_valid_next = 1'b1;
        end
    end

    // result
    always_comb begin
        out_item_next.running_task    = cur_valid_next ? cur_task_next : '0;
        out_item_next.running_present = cur_valid_next;
        out_item_next.switched        = is_sched && found;
        out_item_next.no_task_error   = is_sched && !found && !still;
        out_item_next.queue_full      = push_en && push_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < PRIORITY_LEVELS; l++) begin
                head_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
            cur_task_reg   <= '0;
            cur_level_reg  <= '0;
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_lvl_reg   <= '0;
        end else begin
            for (int l = 0; l < PRIORITY_LEVELS; l++) begin
                head_reg[l] <= head_next[l];
                cnt_reg[l]  <= cnt_next[l];
            end
            cur_task_reg   <= cur_task_next;
            cur_level_reg  <= cur_level_next;
            cur_valid_reg  <= cur_valid_next;
            pend_valid_reg <= pend_valid_next;
            pend_lvl_reg   <= pend_lvl_next;
        end
    end

    // head caches are payload, only meaningful while their level is non-empty
    always_ff @(posedge aclk) begin
        for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            hv_reg[l] <= hv_next[l];
        end
    end

    // queue memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            queue_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= queue_mem_reg[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    generate
        for (genvar g = 0; g < PRIORITY_LEVELS; g++) begin : g_cnt_chk
            a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
                cnt_reg[g] <= CNT_W'(MAX_TASKS))
                else $error("level count above capacity");
        end
    endgenerate

    a_refill_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> $past(pop_en))
        else $error("head refill without a pop");

    a_result_after_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("processed request produced no result");

    a_err_not_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.no_task_error && m_item.switched))
        else $error("error and switch in one result");

    a_idle_task_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.running_present) |-> (m_item.running_task == '0))
        else $error("task id shown with no task running");

endmodule

`default_nettype wire
